// ===== hw/rtl/pprm_pkg.sv =====
`timescale 1ns / 1ps

package pprm_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int SAMPLE_W       = 16;
    localparam int LEVEL_W        = 17;
    localparam int FS_SQ_W        = 32;
    // Normalized mean square stays below 2^51 for every format mix.
    localparam int QUO_W          = 52;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_IS_WIDE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_IS_SIGNED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN       = 2'd2;

    localparam logic [SAMPLE_W-1:0] FS_U8  = 16'd255;
    localparam logic [SAMPLE_W-1:0] FS_S8  = 16'd127;
    localparam logic [SAMPLE_W-1:0] FS_U16 = 16'd65535;
    localparam logic [SAMPLE_W-1:0] FS_S16 = 16'd32767;

    localparam logic [FS_SQ_W-1:0] FS_SQ_U8  = 32'd65025;
    localparam logic [FS_SQ_W-1:0] FS_SQ_S8  = 32'd16129;
    localparam logic [FS_SQ_W-1:0] FS_SQ_U16 = 32'd4294836225;
    localparam logic [FS_SQ_W-1:0] FS_SQ_S16 = 32'd1073676289;

    typedef struct packed {
        logic sample_is_wide;
        logic sample_is_signed;
        logic big_endian;
    } cfg_t;

    typedef struct packed {
        logic take_item;
        logic accum;
        logic start_peak_div;
        logic start_sum_div;
        logic start_sqrt;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } sts_t;

    function automatic logic [SAMPLE_W-1:0] full_scale(cfg_t c);
        logic [SAMPLE_W-1:0] fs;
        if (c.sample_is_wide)
            fs = c.sample_is_signed ? FS_S16 : FS_U16;
        else
            fs = c.sample_is_signed ? FS_S8 : FS_U8;
        return fs;
    endfunction

    function automatic logic [FS_SQ_W-1:0] full_scale_sq(cfg_t c);
        logic [FS_SQ_W-1:0] fs2;
        if (c.sample_is_wide)
            fs2 = c.sample_is_signed ? FS_SQ_S16 : FS_SQ_U16;
        else
            fs2 = c.sample_is_signed ? FS_SQ_S8 : FS_SQ_U8;
        return fs2;
    endfunction

    // Absolute value for signed formats, raw code for unsigned ones.
    function automatic logic [SAMPLE_W-1:0] magnitude(logic [SAMPLE_W-1:0] raw, cfg_t c);
        logic [SAMPLE_W-1:0] b;
        logic [SAMPLE_W-1:0] w;
        logic [SAMPLE_W-1:0] m;
        b = {8'h00, raw[7:0]};
        w = c.big_endian ? {raw[7:0], raw[15:8]} : raw;
        if (!c.sample_is_wide)
            m = (c.sample_is_signed && raw[7]) ? (16'h0100 - b) : b;
        else
            m = (c.sample_is_signed && w[15]) ? (16'h0000 - w) : w;
        return m;
    endfunction

endpackage

// ===== hw/rtl/pcm_peak_rms_meter.sv =====
`timescale 1ns / 1ps

// Peak and RMS level meter for one channel of raw PCM samples (8 or 16 bit, signed or
// unsigned, either byte order). The user must set the format through the configuration port
// only while the meter is idle; the block itself does not enforce this. Each sample item goes
// through S_IDLE, which takes it and registers its magnitude, then S_ACC, which updates
// the peak, the sum of squares and the saturating count. The item flagged tlast then runs
// the normalization: a shared restoring divider at one bit per cycle (32 steps for the peak,
// COUNT_BITS + 64 steps for the mean square) followed by a 26-step square root; the result
// then goes to the output register once that is free, and no new item is taken until then.
// Levels are unsigned Q1.16 relative to full scale, truncated, and may slightly exceed 1.0
// for the most negative code.
module pcm_peak_rms_meter
    import pprm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int FIELD_W   = 2 * LEVEL_W + SAMPLE_W + COUNT_BITS + 1,
    localparam int TDATA_W   = ((FIELD_W + 7) / 8) * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // raw_sample
    input  logic [SAMPLE_W-1:0]  s_axis_tdata,
    // last_sample
    input  logic                 s_axis_tlast,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // peak_level, rms_level, peak_raw, samples_seen, count_saturated, zero fill
    output logic [TDATA_W-1:0]   m_axis_tdata,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    cmd_t                  cmd;
    sts_t                  sts;
    logic [LEVEL_W-1:0]    peak_level;
    logic [LEVEL_W-1:0]    rms_level;
    logic [SAMPLE_W-1:0]   peak_raw;
    logic [COUNT_BITS-1:0] samples_seen;
    logic                  count_saturated;

    assign cfg_ready = 1'b1;

    pprm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pprm_datapath #(
        .COUNT_BITS(COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_sample      (s_axis_tdata),
        .in_last        (s_axis_tlast),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .peak_level     (peak_level),
        .rms_level      (rms_level),
        .peak_raw       (peak_raw),
        .samples_seen   (samples_seen),
        .count_saturated(count_saturated)
    );

    assign m_axis_tdata = TDATA_W'({count_saturated, samples_seen, peak_raw,
                                    rms_level, peak_level});

endmodule

// ===== hw/rtl/pprm_div.sv =====
`timescale 1ns / 1ps

module pprm_div
    import pprm_pkg::*;
#(
    parameter int NUM_W  = 88,
    parameter int DEN_W  = 56,
    parameter int Q_W    = QUO_W,
    parameter int STEP_W = $clog2(NUM_W + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [STEP_W-1:0] steps,
    output logic              busy,
    output logic [Q_W-1:0]    quo
);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;
    logic              ge;

    // Restoring division, one quotient bit per cycle from the top of num.
    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = !diff[DEN_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/pprm_sqrt.sv =====
`timescale 1ns / 1ps

module pprm_sqrt
    import pprm_pkg::*;
#(
    parameter int W = QUO_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   x_in,
    output logic           busy,
    output logic [W/2-1:0] root
);

    localparam int STEPS  = W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [W-1:0]      x_reg;
    logic [W-1:0]      res_reg;
    logic [W-1:0]      bit_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;

    logic [W:0]        trial;
    logic              ge;

    // Digit-by-digit root, one result bit per cycle.
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign ge    = {1'b0, x_reg} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= STEP_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x_in;
            res_reg <= '0;
            bit_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                x_reg   <= x_reg - trial[W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = res_reg[W/2-1:0];

endmodule

// ===== hw/rtl/pprm_datapath.sv =====
`timescale 1ns / 1ps

module pprm_datapath
    import pprm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic                  cfg_data,
    input  logic [SAMPLE_W-1:0]   in_sample,
    input  logic                  in_last,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEVEL_W-1:0]    peak_level,
    output logic [LEVEL_W-1:0]    rms_level,
    output logic [SAMPLE_W-1:0]   peak_raw,
    output logic [COUNT_BITS-1:0] samples_seen,
    output logic                  count_saturated
);

    localparam int SUM_W  = COUNT_BITS + 2 * SAMPLE_W;
    localparam int NUM_W  = SUM_W + 32;
    localparam int DEN_W  = FS_SQ_W + COUNT_BITS;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int PEAK_STEPS = 2 * SAMPLE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    cfg_t                  cfg_reg;
    logic [SAMPLE_W-1:0]   mag_reg;
    logic                  last_reg;
    logic [SAMPLE_W-1:0]   peak_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [LEVEL_W-1:0]    peak_lvl_reg;

    logic                  out_valid_reg;
    logic [LEVEL_W-1:0]    out_peak_lvl_reg;
    logic [LEVEL_W-1:0]    out_rms_reg;
    logic [SAMPLE_W-1:0]   out_peak_raw_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_sat_reg;

    logic [2*SAMPLE_W-1:0] sq;
    logic [DEN_W-1:0]      den_prod;
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [STEP_W-1:0]     div_steps;
    logic                  div_busy;
    logic [QUO_W-1:0]      div_quo;
    logic                  sqrt_busy;
    logic [QUO_W/2-1:0]    sqrt_root;
    logic [LEVEL_W-1:0]    rms_value;

    assign sq       = {{SAMPLE_W{1'b0}}, mag_reg} * {{SAMPLE_W{1'b0}}, mag_reg};
    assign den_prod = DEN_W'(full_scale_sq(cfg_reg)) * DEN_W'(count_reg);

    // The shared divider first forms peak * 2^16 / FS, then sum * 2^32 / (FS^2 * n).
    assign div_start = cmd.start_peak_div | cmd.start_sum_div;
    assign div_num   = cmd.start_peak_div
                       ? {peak_reg, {(NUM_W - SAMPLE_W){1'b0}}}
                       : {sum_reg, 32'd0};
    assign div_den   = cmd.start_peak_div ? DEN_W'(full_scale(cfg_reg)) : den_reg;
    assign div_steps = cmd.start_peak_div ? STEP_W'(PEAK_STEPS) : STEP_W'(NUM_W);

    pprm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .Q_W   (QUO_W),
        .STEP_W(STEP_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .steps(div_steps),
        .busy (div_busy),
        .quo  (div_quo)
    );

    pprm_sqrt #(
        .W(QUO_W)
    ) u_sqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.start_sqrt),
        .x_in (div_quo),
        .busy (sqrt_busy),
        .root (sqrt_root)
    );

    assign rms_value = (count_reg == '0) ? '0 : sqrt_root[LEVEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_is_wide   <= 1'b1;
            cfg_reg.sample_is_signed <= 1'b1;
            cfg_reg.big_endian       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_SAMPLE_IS_WIDE:   cfg_reg.sample_is_wide   <= cfg_data;
                REG_SAMPLE_IS_SIGNED: cfg_reg.sample_is_signed <= cfg_data;
                REG_BIG_ENDIAN:       cfg_reg.big_endian       <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            peak_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.take_item)
                last_reg <= in_last;
            if (cmd.accum)
            begin
                if (mag_reg > peak_reg)
                    peak_reg <= mag_reg;
                // Once the count saturates, only the peak keeps tracking.
                if (count_reg != COUNT_MAX)
                begin
                    sum_reg   <= sum_reg + SUM_W'(sq);
                    count_reg <= count_reg + COUNT_BITS'(1);
                end
            end
            else if (cmd.store)
            begin
                peak_reg  <= '0;
                sum_reg   <= '0;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
            mag_reg <= magnitude(in_sample, cfg_reg);
        if (cmd.start_peak_div)
            den_reg <= den_prod;
        if (cmd.start_sum_div)
            peak_lvl_reg <= div_quo[LEVEL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.store)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            out_peak_lvl_reg <= peak_lvl_reg;
            out_rms_reg      <= rms_value;
            out_peak_raw_reg <= peak_reg;
            out_count_reg    <= count_reg;
            out_sat_reg      <= (count_reg == COUNT_MAX);
        end
    end

    assign sts.last      = last_reg;
    assign sts.div_busy  = div_busy;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign peak_level      = out_peak_lvl_reg;
    assign rms_level       = out_rms_reg;
    assign peak_raw        = out_peak_raw_reg;
    assign samples_seen    = out_count_reg;
    assign count_saturated = out_sat_reg;

endmodule

// ===== hw/rtl/pprm_ctrl.sv =====
`timescale 1ns / 1ps

module pprm_ctrl
    import pprm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_PDIV  = 3'd2;
    localparam logic [2:0] S_PWAIT = 3'd3;
    localparam logic [2:0] S_SWAIT = 3'd4;
    localparam logic [2:0] S_QWAIT = 3'd5;
    localparam logic [2:0] S_STORE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_ACC;
                end
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = sts.last ? S_PDIV : S_IDLE;
            end
            S_PDIV:
            begin
                cmd.start_peak_div = 1'b1;
                state_next         = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.start_sum_div = 1'b1;
                    state_next        = S_SWAIT;
                end
            end
            S_SWAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.start_sqrt = 1'b1;
                    state_next     = S_QWAIT;
                end
            end
            S_QWAIT:
            begin
                if (!sts.sqrt_busy)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                // Hold here while a previous result still waits downstream.
                if (sts.out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
